// File: rtl/bdd_pkg.sv
// Shared types, constants and decode helpers for the binary decimal decoder.
// No dependencies; imported by bdd_mac and binary_decimal_decoder.
`timescale 1ns / 1ps
`default_nettype none
package bdd_pkg;

	localparam int unsigned MAX_INT_DIGITS   = 18;
	localparam int unsigned MAX_FRAC_DIGITS  = 18;
	localparam int unsigned DIGITS_PER_GROUP = 9;

	localparam logic [5:0] MAX_PRECISION = 6'd36;
	localparam logic [5:0] PREC_RESET    = 6'd10;
	localparam logic [5:0] SCALE_RESET   = 6'd0;
	localparam logic [7:0] SIGN_FLIP     = 8'h80;

	localparam logic [1:0] REG_PRECISION = 2'd0;
	localparam logic [1:0] REG_SCALE     = 2'd1;

	localparam logic [59:0] POW10 [19] = '{
		60'd1, 60'd10, 60'd100, 60'd1000, 60'd10000, 60'd100000, 60'd1000000,
		60'd10000000, 60'd100000000, 60'd1000000000, 60'd10000000000,
		60'd100000000000, 60'd1000000000000, 60'd10000000000000,
		60'd100000000000000, 60'd1000000000000000, 60'd10000000000000000,
		60'd100000000000000000, 60'd1000000000000000000
	};

	typedef struct packed {
		logic [3:0] id_rem;
		logic [2:0] int_pb;
		logic [4:0] int_l;
		logic [3:0] fd_rem;
		logic [4:0] frac_full;
		logic [2:0] frac_pb;
		logic [4:0] total;
		logic [5:0] fd;
		logic       err;
	} cfg_t;

	function automatic logic [2:0] digit_bytes(input logic [3:0] d);
		logic [2:0] r;
		unique case (d)
			4'd0:                      r = 3'd0;
			4'd1, 4'd2:                r = 3'd1;
			4'd3, 4'd4:                r = 3'd2;
			4'd5, 4'd6:                r = 3'd3;
			4'd7, 4'd8, 4'd9:          r = 3'd4;
			default:                   r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [29:0] group_pow10(input logic [3:0] d);
		logic [29:0] r;
		unique case (d)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			4'd9:    r = 30'd1000000000;
			default: r = 30'd1;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] div9(input logic [5:0] x);
		return (x >= 6'd36) ? 3'd4 : (x >= 6'd27) ? 3'd3 :
			(x >= 6'd18) ? 3'd2 : (x >= 6'd9) ? 3'd1 : 3'd0;
	endfunction

	function automatic cfg_t derive(input logic [5:0] prec, input logic [5:0] scale);
		logic [5:0] p;
		logic [5:0] s;
		logic [5:0] id;
		logic [2:0] iq;
		logic [2:0] fq;
		logic [3:0] ir;
		logic [3:0] fr;
		cfg_t       c;
		p  = (prec == 6'd0) ? 6'd1 : (prec > MAX_PRECISION) ? MAX_PRECISION : prec;
		s  = (scale > p) ? p : scale;
		id = p - s;
		iq = div9(id);
		fq = div9(s);
		ir = 4'(id - {3'd0, iq} * 6'd9);
		fr = 4'(s - {3'd0, fq} * 6'd9);
		c.id_rem    = ir;
		c.int_pb    = digit_bytes(ir);
		c.int_l     = {2'd0, digit_bytes(ir)} + {iq, 2'b00};
		c.fd_rem    = fr;
		c.frac_full = {fq, 2'b00};
		c.frac_pb   = digit_bytes(fr);
		c.total     = c.int_l + c.frac_full + {2'd0, c.frac_pb};
		c.fd        = s;
		c.err       = (id > 6'(MAX_INT_DIGITS)) || (s > 6'(MAX_FRAC_DIGITS));
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/bdd_mac.sv
// Group multiply-add: acc * 10^d + group, modulo 2^60, as two 30-bit products.
// Depends on bdd_pkg for the power-of-ten table.
`timescale 1ns / 1ps
`default_nettype none
module bdd_mac
	import bdd_pkg::*;
(
	input  wire logic [59:0] acc,
	input  wire logic [3:0]  mult_sel,
	input  wire logic [31:0] grp,
	output logic      [59:0] sum
);

	logic [29:0] mult;
	logic [59:0] prod_lo;
	logic [59:0] prod_hi;

	assign mult    = group_pow10(mult_sel);
	assign prod_lo = {30'd0, acc[29:0]} * {30'd0, mult};
	assign prod_hi = {30'd0, acc[59:30]} * {30'd0, mult};
	assign sum     = prod_lo + {prod_hi[29:0], 30'd0} + {28'd0, grp};

endmodule
`default_nettype wire

// File: rtl/binary_decimal_decoder.sv
// Result: accepting the last byte of a value loads stage 1; out_valid rises when it moves to stage 2.
// Throughput: one byte per cycle; input stalls only while both result stages hold
// a value and out_ready is low. Multiply-add and fraction digit count are in separate stages.
// Reset: value state cleared, precision 10, scale 0, no result pending.
// Depends on bdd_pkg and bdd_mac.
`timescale 1ns / 1ps
`default_nettype none
module binary_decimal_decoder
	import bdd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_negative,
	output logic      [59:0] integral_part,
	output logic      [59:0] fractional_part,
	output logic      [4:0]  leading_zeros,
	output logic      [4:0]  bytes_used,
	output logic             format_error
);

	logic [5:0]  prec_q;
	logic [5:0]  scale_q;
	cfg_t        der_q;
	logic [4:0]  pos_q;
	logic        neg_q;
	logic [31:0] grp_q;
	logic [59:0] iacc_q;
	logic [59:0] facc_q;

	logic        v_s1;
	logic        neg_s1;
	logic [59:0] ip_s1;
	logic [59:0] fp_s1;
	logic [5:0]  fd_s1;
	logic [4:0]  total_s1;
	logic        err_s1;

	logic        v_s2;
	logic        neg_s2;
	logic [59:0] ip_s2;
	logic [59:0] fp_s2;
	logic [4:0]  zeros_s2;
	logic [4:0]  total_s2;
	logic        err_s2;

	logic [5:0]  prec_nx;
	logic [5:0]  scale_nx;
	logic        cfg_hit;
	logic        accept;
	logic        out_adv;
	logic        first;
	logic        neg_eff;
	logic [7:0]  b;
	logic [31:0] grp_new;
	logic [5:0]  pos1;
	logic [5:0]  pdiff;
	logic [4:0]  fpos;
	logic        to_int;
	logic        int_end_p;
	logic        int_end_f;
	logic        f_in_full;
	logic        grp_end;
	logic        last;
	logic [3:0]  mult_sel;
	logic [59:0] acc_sel;
	logic [59:0] mac_sum;
	logic [59:0] ip_fin;
	logic [59:0] fp_fin;
	logic [4:0]  nd;
	logic [5:0]  nd6;
	logic [4:0]  zeros;

	// config write path
	always_comb begin
		prec_nx  = prec_q;
		scale_nx = scale_q;
		cfg_hit  = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_PRECISION: begin
					prec_nx = cfg_data;
					cfg_hit = 1'b1;
				end
				REG_SCALE: begin
					scale_nx = cfg_data;
					cfg_hit  = 1'b1;
				end
				default: cfg_hit = 1'b0;
			endcase
		end
	end

	// handshake
	assign out_adv  = !v_s2 || out_ready;
	assign in_ready = !v_s1 || out_adv;
	assign accept   = in_valid && in_ready;

	// byte decode
	always_comb begin
		first     = (pos_q == 5'd0);
		neg_eff   = first ? !data_byte[7] : neg_q;
		b         = data_byte ^ (first ? SIGN_FLIP : 8'h00) ^ {8{neg_eff}};
		grp_new   = {grp_q[23:0], b};
		pos1      = {1'b0, pos_q} + 6'd1;
		pdiff     = pos1 - {3'd0, der_q.int_pb};
		fpos      = pos_q - der_q.int_l;
		to_int    = pos_q < der_q.int_l;
		int_end_p = (pos1 == {3'd0, der_q.int_pb});
		int_end_f = (pos_q >= {2'd0, der_q.int_pb}) && (pdiff[1:0] == 2'b00);
		f_in_full = fpos < der_q.frac_full;
		if (to_int) begin
			grp_end  = int_end_p || int_end_f;
			mult_sel = int_end_p ? der_q.id_rem : 4'(DIGITS_PER_GROUP);
			acc_sel  = iacc_q;
		end else if (f_in_full) begin
			grp_end  = (fpos[1:0] == 2'b11);
			mult_sel = 4'(DIGITS_PER_GROUP);
			acc_sel  = facc_q;
		end else begin
			grp_end  = (({1'b0, fpos} - {1'b0, der_q.frac_full} + 6'd1)
				== {3'd0, der_q.frac_pb});
			mult_sel = der_q.fd_rem;
			acc_sel  = facc_q;
		end
		last   = pos1 >= {1'b0, der_q.total};
		ip_fin = (grp_end && to_int) ? mac_sum : iacc_q;
		fp_fin = (grp_end && !to_int) ? mac_sum : facc_q;
	end

	bdd_mac u_mac (
		.acc      (acc_sel),
		.mult_sel (mult_sel),
		.grp      (grp_new),
		.sum      (mac_sum)
	);

	// value state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q  <= PREC_RESET;
			scale_q <= SCALE_RESET;
			der_q   <= derive(PREC_RESET, SCALE_RESET);
			pos_q   <= 5'd0;
			neg_q   <= 1'b0;
			grp_q   <= 32'd0;
			iacc_q  <= 60'd0;
			facc_q  <= 60'd0;
		end else if (cfg_hit) begin
			prec_q  <= prec_nx;
			scale_q <= scale_nx;
			der_q   <= derive(prec_nx, scale_nx);
			pos_q   <= 5'd0;
			neg_q   <= 1'b0;
			grp_q   <= 32'd0;
			iacc_q  <= 60'd0;
			facc_q  <= 60'd0;
		end else if (accept) begin
			if (last) begin
				pos_q  <= 5'd0;
				neg_q  <= 1'b0;
				grp_q  <= 32'd0;
				iacc_q <= 60'd0;
				facc_q <= 60'd0;
			end else begin
				pos_q  <= pos1[4:0];
				neg_q  <= neg_eff;
				grp_q  <= grp_end ? 32'd0 : grp_new;
				iacc_q <= ip_fin;
				facc_q <= fp_fin;
			end
		end
	end

	// stage 1: completed value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept && last) begin
			v_s1 <= 1'b1;
		end else if (out_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			neg_s1   <= neg_eff;
			ip_s1    <= ip_fin;
			fp_s1    <= fp_fin;
			fd_s1    <= der_q.fd;
			total_s1 <= der_q.total;
			err_s1   <= der_q.err;
		end
	end

	// digit count of the fraction
	always_comb begin
		nd = 5'd0;
		for (int k = 0; k < 19; k++) begin
			nd = nd + {4'd0, (fp_s1 >= POW10[k])};
		end
		nd6   = {1'b0, nd};
		zeros = (nd6 >= fd_s1) ? 5'd0 : 5'(fd_s1 - nd6);
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && v_s1) begin
			neg_s2   <= neg_s1;
			ip_s2    <= err_s1 ? 60'd0 : ip_s1;
			fp_s2    <= err_s1 ? 60'd0 : fp_s1;
			zeros_s2 <= err_s1 ? 5'd0 : zeros;
			total_s2 <= total_s1;
			err_s2   <= err_s1;
		end
	end

	assign out_valid       = v_s2;
	assign is_negative     = neg_s2;
	assign integral_part   = ip_s2;
	assign fractional_part = fp_s2;
	assign leading_zeros   = zeros_s2;
	assign bytes_used      = total_s2;
	assign format_error    = err_s2;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && err_s2) |-> (ip_s2 == 60'd0 && fp_s2 == 60'd0 && zeros_s2 == 5'd0))
		else $error("format error transaction carries nonzero parts");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < der_q.total)
		else $error("byte position past value length");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !out_ready) |=> (v_s1 && $stable(ip_s1) && $stable(fp_s1)))
		else $error("stage 1 lost a stalled value");

	a_last_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> v_s1)
		else $error("last byte did not produce a pending result");

	a_zeros_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !err_s2) |-> (zeros_s2 <= 5'(MAX_FRAC_DIGITS)))
		else $error("leading zero count out of range");
`endif

endmodule
`default_nettype wire
